/* hdl/peak_envelope_compressor_top_defines.svh */
// Assertion macros used by the checker of the compressor.
`ifndef PEAK_ENVELOPE_COMPRESSOR_TOP_DEFINES_SVH
`define PEAK_ENVELOPE_COMPRESSOR_TOP_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define PEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pec_pkg.sv */
`timescale 1ns / 1ps

package pec_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 16;
  localparam int IR_BITS     = 17;
  localparam int IR_FRAC     = 16;
  localparam int CFG_BITS    = (SAMPLE_BITS > IR_BITS) ? SAMPLE_BITS : IR_BITS;
  localparam int IDX_BITS    = 2;
  localparam int CNT_BITS    = $clog2(SAMPLE_BITS);
  localparam int DVD_BITS    = 2 * SAMPLE_BITS + 2;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_INV_RATIO = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_ATTACK    = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_RELEASE   = 2'd3;

  localparam logic [SAMPLE_BITS-1:0] THR_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [IR_BITS-1:0]     IR_RESET  = {1'b1, {IR_FRAC{1'b0}}};

  typedef struct packed {
    logic load_in;
    logic mul_a;
    logic mul_b;
    logic env_upd;
    logic num_mul;
    logic num_add;
    logic dvd_mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } pec_cmd_t;

  typedef struct packed {
    logic active;
  } pec_sts_t;

endpackage

/* hdl/peak_envelope_compressor_top.sv */
`timescale 1ns / 1ps

// Feed-forward peak compressor: one signed Q1.23 sample per input word, one
// result word per input. A sample whose envelope stays at or below the threshold
// passes through; a compressed sample also runs through the one-bit-per-cycle
// restoring divider that forms the 24-bit output magnitude. The input is taken
// again as soon as the result sits in the output register, so a stalled sink
// lets one more sample through the datapath and then holds the input.
// in_tlast clears the shared envelope after that sample.
// The user must write registers through cfg_* only while no sample is in
// flight; the block itself does not enforce this.
module peak_envelope_compressor_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pec_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [pec_pkg::CFG_BITS-1:0]    cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pec_pkg::SAMPLE_BITS-1:0] in_tdata,   // [23:0] sample_in
  input  logic                            in_tlast,   // end_of_block
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pec_pkg::SAMPLE_BITS-1:0] out_tdata,  // [23:0] sample_out
  output logic [0:0]                      out_tuser   // [0] gain_active
);

  pec_pkg::pec_cmd_t cmd;
  pec_pkg::pec_sts_t sts;

  pec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pec_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata),
    .in_eob     (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_sample (out_tdata),
    .out_gain   (out_tuser[0])
  );

endmodule

/* hdl/pec_ctrl.sv */
`timescale 1ns / 1ps

module pec_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  pec_pkg::pec_sts_t sts,
  output pec_pkg::pec_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULA = 4'd1;
  localparam logic [3:0] S_MULB = 4'd2;
  localparam logic [3:0] S_ENV  = 4'd3;
  localparam logic [3:0] S_NUMM = 4'd4;
  localparam logic [3:0] S_NUMA = 4'd5;
  localparam logic [3:0] S_DVD  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [pec_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_ENV;
      end
      S_ENV: begin
        cmd.env_upd = 1'b1;
        state_nxt   = sts.active ? S_NUMM : S_DONE;
      end
      S_NUMM: begin
        cmd.num_mul = 1'b1;
        state_nxt   = S_NUMA;
      end
      S_NUMA: begin
        cmd.num_add = 1'b1;
        state_nxt   = S_DVD;
      end
      S_DVD: begin
        cmd.dvd_mul = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = pec_pkg::CNT_BITS'(pec_pkg::SAMPLE_BITS - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* hdl/pec_dp.sv */
`timescale 1ns / 1ps

module pec_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pec_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [pec_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic [pec_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  logic                              in_eob,
  input  pec_pkg::pec_cmd_t                 cmd,
  output pec_pkg::pec_sts_t                 sts,
  output logic [pec_pkg::SAMPLE_BITS-1:0]   out_sample,
  output logic                              out_gain
);

  localparam int SB   = pec_pkg::SAMPLE_BITS;
  localparam int CB   = pec_pkg::COEFF_BITS;
  localparam int IRB  = pec_pkg::IR_BITS;
  localparam int DVDB = pec_pkg::DVD_BITS;

  localparam logic [CB:0]       C_ONE    = {1'b1, {CB{1'b0}}};
  localparam logic [CB+SB+1:0]  ENV_RND  = (CB+SB+2)'(1) << (CB - 1);
  localparam logic [SB+IRB:0]   NUM_RND  = (SB+IRB+1)'(1) << (pec_pkg::IR_FRAC - 1);
  localparam logic [SB-1:0]     POS_LIM  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]     NEG_LIM  = {1'b1, {(SB-1){1'b0}}};

  logic [SB-1:0]     thr_r;
  logic [IRB-1:0]    ir_r;
  logic [CB-1:0]     att_r;
  logic [CB-1:0]     rel_r;
  logic [SB-1:0]     envelope_r;

  logic [SB-1:0]     raw_r;
  logic [SB-1:0]     mag_r;
  logic              eob_r;
  logic [CB-1:0]     c_r;
  logic [CB+SB-1:0]  pa_r;
  logic [CB+SB:0]    pb_r;
  logic [SB-1:0]     env_w_r;
  logic              active_r;
  logic [SB+IRB-1:0] pn_r;
  logic [SB:0]       num_r;
  logic [DVDB-1:0]   dvd_r;
  logic [SB-1:0]     rem_r;
  logic [SB-1:0]     quo_r;
  logic              sat_r;
  logic [SB-1:0]     out_sample_r;
  logic              out_gain_r;

  logic [SB-1:0]     in_mag;
  logic [CB+SB+1:0]  env_sum;
  logic [SB-1:0]     env_new;
  logic [SB-1:0]     env_diff;
  logic [SB+IRB:0]   pn_rnd;
  logic [DVDB-1:0]   dvd_prod;
  logic [SB:0]       trial;
  logic              trial_ge;
  logic [SB:0]       trial_sub;
  logic              neg;
  logic [SB-1:0]     q_lim;
  logic [SB-1:0]     q_mag;
  logic [SB-1:0]     result;

  assign in_mag   = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;

  assign env_sum  = {2'b00, pa_r} + {1'b0, pb_r} + ENV_RND;
  assign env_new  = env_sum[CB +: SB];
  assign sts.active = env_new > thr_r;

  assign env_diff = env_w_r - thr_r;
  assign pn_rnd   = {1'b0, pn_r} + NUM_RND;
  assign dvd_prod = {1'b0, mag_r} * num_r;

  assign trial     = {rem_r, quo_r[SB-1]};
  assign trial_ge  = trial >= {1'b0, env_w_r};
  assign trial_sub = trial - {1'b0, env_w_r};

  assign neg    = raw_r[SB-1];
  assign q_lim  = neg ? NEG_LIM : POS_LIM;
  assign q_mag  = (sat_r || (quo_r > q_lim)) ? q_lim : quo_r;
  assign result = !active_r ? raw_r : (neg ? (~q_mag + 1'b1) : q_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= pec_pkg::THR_RESET;
      ir_r  <= pec_pkg::IR_RESET;
      att_r <= '0;
      rel_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pec_pkg::REG_THRESHOLD: thr_r <= cfg_wdata[SB-1:0];
        pec_pkg::REG_INV_RATIO: ir_r  <= cfg_wdata[IRB-1:0];
        pec_pkg::REG_ATTACK:    att_r <= cfg_wdata[CB-1:0];
        pec_pkg::REG_RELEASE:   rel_r <= cfg_wdata[CB-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      envelope_r <= '0;
    end else if (cmd.env_upd) begin
      envelope_r <= eob_r ? '0 : env_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r <= in_sample;
      mag_r <= in_mag;
      eob_r <= in_eob;
      c_r   <= (in_mag > envelope_r) ? att_r : rel_r;
    end
    if (cmd.mul_a) begin
      pa_r <= c_r * envelope_r;
    end
    if (cmd.mul_b) begin
      pb_r <= (C_ONE - {1'b0, c_r}) * mag_r;
    end
    if (cmd.env_upd) begin
      env_w_r  <= env_new;
      active_r <= sts.active;
    end
    if (cmd.num_mul) begin
      pn_r <= env_diff * ir_r;
    end
    if (cmd.num_add) begin
      num_r <= {1'b0, thr_r} + pn_rnd[pec_pkg::IR_FRAC +: SB+1];
    end
    if (cmd.dvd_mul) begin
      dvd_r <= dvd_prod + {{(DVDB-SB+1){1'b0}}, env_w_r[SB-1:1]};
    end
    if (cmd.div_init) begin
      sat_r <= dvd_r[DVDB-1:SB] >= {2'b00, env_w_r};
      rem_r <= dvd_r[SB +: SB];
      quo_r <= dvd_r[SB-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[SB-1:0] : trial[SB-1:0];
      quo_r <= {quo_r[SB-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      out_sample_r <= result;
      out_gain_r   <= active_r;
    end
  end

  assign out_sample = out_sample_r;
  assign out_gain   = out_gain_r;

endmodule

/* hdl/pec_checker.sv */
`timescale 1ns / 1ps
`include "peak_envelope_compressor_top_defines.svh"

module pec_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pec_pkg::SAMPLE_BITS-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);

  `PEC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")
  `PEC_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second word taken while one is in flight")
  `PEC_ASSERT_SAME(a_result_after_work, $rose(out_tvalid), !$past(in_tready), "result word appeared without finished work")

endmodule

bind peak_envelope_compressor_top pec_checker u_pec_checker (.*);
